// ===== hw/rtl/rxbr_pkg.sv =====
package rxbr_pkg;

   // default sizes
   localparam int DEPTH_DEF     = 256;
   localparam int MAX_BURST_DEF = 64;

   // request opcodes
   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_BULK  = 2'd2,
      OP_QUERY = 2'd3
   } opcode_type;

   // sequencer states
   typedef enum logic [0:0] {
      S_IDLE = 1'b0,
      S_READ = 1'b1
   } state_type;

   // request payload
   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  rx_byte;
      logic [6:0]  req_len;
   } req_type;

   // result payload
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        last;
      logic [8:0]  fill_count;
      logic        dropped;
   } rsp_type;

endpackage

// ===== hw/rtl/rxbr_ram.sv =====
module rxbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/rx_byte_ring_fifo.sv =====
// Receive byte ring FIFO. Each request carries an opcode: push stores a byte
// (or drops it and flags the drop when the ring is full), pop returns one
// byte (or a result without a byte when the ring is empty), bulk read
// returns up to req_len bytes (saturated to MAX_BURST and clamped to the
// bytes held) one result per byte with last on the final one, and query
// returns the fill count. Push and query give their result from the output
// register. A bulk read gives one byte per cycle while the output is not
// stalled, and no request is taken until a read is done: the ring memory has
// a registered read port, so each read is issued before its byte reaches the
// output register. A bulk read with nothing to return gives no result. The
// ring memory needs no clearing after reset, since no entry is read before
// it was written; the block accepts requests as soon as reset is released.
module rx_byte_ring_fifo
   #(
   parameter int DEPTH     = rxbr_pkg::DEPTH_DEF,
   parameter int MAX_BURST = rxbr_pkg::MAX_BURST_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rxbr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rxbr_pkg::rsp_type rsp_data
);

   import rxbr_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int BW = $clog2(MAX_BURST + 1);
   localparam int LW = (CW > BW) ? CW : BW;

   state_type      state_ff, state_in;
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [BW-1:0]  rem_ff, rem_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic           ram_we;
   logic           ram_re;
   logic [AW-1:0]  ram_ra;
   logic [7:0]     ram_rd_data;

   logic           out_free;
   logic           req_fire;
   logic           ring_full;
   logic [AW-1:0]  wr_next;
   logic [AW-1:0]  rd_next;
   logic [BW-1:0]  req_sat;
   logic [BW-1:0]  burst_n;

   // fill count masked to the 9-bit result field
   function automatic logic [8:0] to_fill(input logic [CW-1:0] c);
      logic [CW+8:0] e;
      e = {9'b0, c};
      return e[8:0];
   endfunction

   // ring memory
   rxbr_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_data.rx_byte),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd_data)
   );

   // pointer wrap and burst length
   assign wr_next   = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
   assign rd_next   = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
   assign ring_full = (count_ff >= CW'(DEPTH));
   assign req_sat   = (req_data.req_len > 7'(MAX_BURST)) ? BW'(MAX_BURST)
                                                         : BW'(req_data.req_len);
   assign burst_n   = (LW'(req_sat) > LW'(count_ff)) ? BW'(count_ff) : req_sat;

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer: next state, pointer updates, memory access and result
   always_comb begin
      state_in     = state_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_ra       = rd_ptr_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_data.opcode)
                  OP_PUSH: begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.out_byte   = '0;
                     rsp_in.byte_valid = 1'b0;
                     rsp_in.last       = 1'b1;
                     rsp_in.dropped    = ring_full;
                     rsp_in.fill_count = to_fill(count_ff);
                     if (!ring_full) begin
                        ram_we            = 1'b1;
                        wr_ptr_in         = wr_next;
                        count_in          = count_ff + CW'(1);
                        rsp_in.fill_count = to_fill(count_ff + CW'(1));
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in      = 1'b1;
                        rsp_in.out_byte   = '0;
                        rsp_in.byte_valid = 1'b0;
                        rsp_in.last       = 1'b1;
                        rsp_in.dropped    = 1'b0;
                        rsp_in.fill_count = to_fill(count_ff);
                     end else begin
                        ram_re   = 1'b1;
                        rem_in   = BW'(1);
                        state_in = S_READ;
                     end
                  end
                  OP_BULK: begin
                     if (burst_n != '0) begin
                        ram_re   = 1'b1;
                        rem_in   = burst_n;
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.out_byte   = '0;
                     rsp_in.byte_valid = 1'b0;
                     rsp_in.last       = 1'b1;
                     rsp_in.dropped    = 1'b0;
                     rsp_in.fill_count = to_fill(count_ff);
                  end
               endcase
            end
         end
         S_READ: begin
            // memory data is held until the output register takes it
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.out_byte   = ram_rd_data;
               rsp_in.byte_valid = 1'b1;
               rsp_in.last       = (rem_ff == BW'(1));
               rsp_in.dropped    = 1'b0;
               rsp_in.fill_count = to_fill(count_ff - CW'(1));
               rd_ptr_in         = rd_next;
               count_in          = count_ff - CW'(1);
               rem_in            = rem_ff - BW'(1);
               if (rem_ff == BW'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  ram_re = 1'b1;
                  ram_ra = rd_next;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // fill count never exceeds the ring size
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count above ring depth");

   // a pending read always has bytes left and never more than the ring holds
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (rem_ff != '0) && (LW'(rem_ff) <= LW'(count_ff)))
      else $error("burst remainder out of range");

   // a push into a ring with room grows the count by one
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.opcode == OP_PUSH) && !ring_full)
      |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("push did not advance fill count");

   // a byte result is only produced while draining the ring
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_ready) && rsp_in.byte_valid)
      |-> (state_ff == S_READ))
      else $error("byte result outside a read");

endmodule
